// ===== hw/rtl/cna_pkg.sv =====
package cna_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_DIV = 2'd3;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_SAT = 2'd1;
   localparam logic [1:0] ST_DZ  = 2'd2;

   typedef struct packed {
      logic [1:0]                   cmd;
      logic signed [DATA_WIDTH-1:0] left_real;
      logic signed [DATA_WIDTH-1:0] left_imag;
      logic signed [DATA_WIDTH-1:0] right_real;
      logic signed [DATA_WIDTH-1:0] right_imag;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result_real;
      logic signed [DATA_WIDTH-1:0] result_imag;
      logic [1:0]                   status;
   } rsp_type;

   // side information that rides along the divider pipeline
   typedef struct packed {
      logic       neg_re;
      logic       neg_im;
      logic       ovf_re;
      logic       ovf_im;
      logic       dz;
      logic [1:0] cmd;
   } flags_type;

endpackage

// ===== hw/rtl/complex_number_alu_unit.sv =====
// Complex arithmetic unit on signed fixed-point operands (Q16.16 by default):
// add, subtract, multiply and divide (conjugate over squared magnitude, exact).
// Multiply and divide truncate toward zero; every part saturates, status 1
// flags it, status 2 flags a zero divisor (result zero). One item enters per
// cycle unless the pipeline holds; most of its stages belong to the divider,
// which resolves one quotient bit per stage. All items go through the same
// stages, so results leave in order. While a result waits on rsp_stall the
// whole pipeline holds and req_stall rises.
module complex_number_alu_unit #(
   parameter int FRAC_BITS = cna_pkg::FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cna_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cna_pkg::rsp_type rsp_data
);
   import cna_pkg::*;

   localparam int DW   = DATA_WIDTH;
   // signed width of an exact sum of two products
   localparam int PW   = 2 * DW + 2;
   // remainder width: covers numerator shifted by FRAC_BITS and divisor << DW
   localparam int XW   = PW + FRAC_BITS + DW;
   localparam logic [XW-1:0] HALF = XW'(1) << (DW - 1);

   logic enable;

   // stage 1: input register
   logic    v1_ff;
   req_type r1_ff;

   // stage 2: products
   logic                   v2;
   logic [1:0]             c2;
   logic signed [DW:0]     as_re2, as_im2;
   logic signed [2*DW-1:0] p_rr2, p_ii2, p_ri2, p_ir2, sq_r2, sq_i2;

   // stage 3: combined signed parts and divisor
   logic                 v3_ff;
   logic [1:0]           c3_ff;
   logic signed [PW-1:0] re3_ff, im3_ff;
   logic [PW-1:0]        den3_ff;
   logic signed [PW-1:0] re3_in, im3_in;

   // stage 4: sign/magnitude, scaling, overflow check
   logic          neg_re, neg_im;
   logic [PW-1:0] mag_re, mag_im;
   logic [XW-1:0] val_re, val_im, den_top;
   flags_type     f4_in;

   logic          vd [DW+1];
   flags_type     fd [DW+1];
   logic [PW-1:0] dd [DW+1];
   logic [XW-1:0] rre [DW+1];
   logic [XW-1:0] rim [DW+1];
   logic [DW-1:0] qre [DW+1];
   logic [DW-1:0] qim [DW+1];

   // output stage
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   rsp_type       rsp_data_in;
   logic [XW-1:0] fin_re, fin_im;
   logic          sat_re, sat_im;

   // hold every stage while the result register is full and blocked
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         r1_ff <= req_data;
      end
   end

   cna_mul_stage #(.DW(DW)) u_mul (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .in_valid     (v1_ff),
      .in_req       (r1_ff),
      .out_valid_ff (v2),
      .out_cmd_ff   (c2),
      .out_as_re_ff (as_re2),
      .out_as_im_ff (as_im2),
      .out_p_rr_ff  (p_rr2),
      .out_p_ii_ff  (p_ii2),
      .out_p_ri_ff  (p_ri2),
      .out_p_ir_ff  (p_ir2),
      .out_sq_r_ff  (sq_r2),
      .out_sq_i_ff  (sq_i2)
   );

   // combine products: (ac-bd, ad+bc) for multiply, (ac+bd, bc-ad) for divide
   always_comb begin
      unique case (c2)
         CMD_MUL: begin
            re3_in = PW'(p_rr2) - PW'(p_ii2);
            im3_in = PW'(p_ri2) + PW'(p_ir2);
         end
         CMD_DIV: begin
            re3_in = PW'(p_rr2) + PW'(p_ii2);
            im3_in = PW'(p_ir2) - PW'(p_ri2);
         end
         default: begin
            re3_in = PW'(as_re2);
            im3_in = PW'(as_im2);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (enable) begin
         v3_ff <= v2;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         c3_ff   <= c2;
         re3_ff  <= re3_in;
         im3_ff  <= im3_in;
         den3_ff <= PW'($unsigned(sq_r2)) + PW'($unsigned(sq_i2));
      end
   end

   // split into sign and magnitude; scale for multiply and divide
   always_comb begin
      neg_re  = re3_ff[PW-1];
      neg_im  = im3_ff[PW-1];
      mag_re  = neg_re ? PW'(-re3_ff) : PW'(re3_ff);
      mag_im  = neg_im ? PW'(-im3_ff) : PW'(im3_ff);
      den_top = XW'(den3_ff) << DW;
      unique case (c3_ff)
         CMD_MUL: begin
            val_re = XW'(mag_re >> FRAC_BITS);
            val_im = XW'(mag_im >> FRAC_BITS);
         end
         CMD_DIV: begin
            val_re = XW'(mag_re) << FRAC_BITS;
            val_im = XW'(mag_im) << FRAC_BITS;
         end
         default: begin
            val_re = XW'(mag_re);
            val_im = XW'(mag_im);
         end
      endcase
      f4_in.cmd    = c3_ff;
      f4_in.neg_re = neg_re;
      f4_in.neg_im = neg_im;
      f4_in.dz     = (den3_ff == '0);
      // quotient of 2**DW or more always saturates
      f4_in.ovf_re = (val_re >= den_top);
      f4_in.ovf_im = (val_im >= den_top);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd[0] <= 1'b0;
      end else if (enable) begin
         vd[0] <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         fd[0]  <= f4_in;
         dd[0]  <= den3_ff;
         rre[0] <= val_re;
         rim[0] <= val_im;
         qre[0] <= '0;
         qim[0] <= '0;
      end
   end

   // restoring divider, most significant quotient bit first
   for (genvar i = 0; i < DW; i++) begin : g_div
      cna_div_step #(
         .XW   (XW),
         .DENW (PW),
         .QW   (DW),
         .BIT  (DW - 1 - i)
      ) u_step (
         .clock         (clock),
         .reset         (reset),
         .enable        (enable),
         .in_valid      (vd[i]),
         .in_flags      (fd[i]),
         .in_den        (dd[i]),
         .in_rem_re     (rre[i]),
         .in_rem_im     (rim[i]),
         .in_q_re       (qre[i]),
         .in_q_im       (qim[i]),
         .out_valid_ff  (vd[i+1]),
         .out_flags_ff  (fd[i+1]),
         .out_den_ff    (dd[i+1]),
         .out_rem_re_ff (rre[i+1]),
         .out_rem_im_ff (rim[i+1]),
         .out_q_re_ff   (qre[i+1]),
         .out_q_im_ff   (qim[i+1])
      );
   end

   // pick the magnitude, saturate, restore the sign
   always_comb begin
      if (fd[DW].cmd == CMD_DIV) begin
         fin_re = XW'(qre[DW]);
         fin_im = XW'(qim[DW]);
      end else begin
         fin_re = rre[DW];
         fin_im = rim[DW];
      end
      sat_re = (fd[DW].cmd == CMD_DIV && fd[DW].ovf_re) ||
               (fd[DW].neg_re ? (fin_re > HALF) : (fin_re > HALF - XW'(1)));
      sat_im = (fd[DW].cmd == CMD_DIV && fd[DW].ovf_im) ||
               (fd[DW].neg_im ? (fin_im > HALF) : (fin_im > HALF - XW'(1)));
      if (sat_re) begin
         rsp_data_in.result_real = fd[DW].neg_re ? DW'(HALF) : DW'(HALF - XW'(1));
      end else begin
         rsp_data_in.result_real = fd[DW].neg_re ? -DW'(fin_re) : DW'(fin_re);
      end
      if (sat_im) begin
         rsp_data_in.result_imag = fd[DW].neg_im ? DW'(HALF) : DW'(HALF - XW'(1));
      end else begin
         rsp_data_in.result_imag = fd[DW].neg_im ? -DW'(fin_im) : DW'(fin_im);
      end
      rsp_data_in.status = (sat_re || sat_im) ? ST_SAT : ST_OK;
      // zero divisor overrides everything
      if (fd[DW].cmd == CMD_DIV && fd[DW].dz) begin
         rsp_data_in.result_real = '0;
         rsp_data_in.result_imag = '0;
         rsp_data_in.status      = ST_DZ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= vd[DW];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== hw/rtl/cna_div_step.sv =====
module cna_div_step #(
   parameter int XW   = 114,
   parameter int DENW = 66,
   parameter int QW   = 32,
   parameter int BIT  = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  cna_pkg::flags_type  in_flags,
   input  logic [DENW-1:0]     in_den,
   input  logic [XW-1:0]       in_rem_re,
   input  logic [XW-1:0]       in_rem_im,
   input  logic [QW-1:0]       in_q_re,
   input  logic [QW-1:0]       in_q_im,
   output logic                out_valid_ff,
   output cna_pkg::flags_type  out_flags_ff,
   output logic [DENW-1:0]     out_den_ff,
   output logic [XW-1:0]       out_rem_re_ff,
   output logic [XW-1:0]       out_rem_im_ff,
   output logic [QW-1:0]       out_q_re_ff,
   output logic [QW-1:0]       out_q_im_ff
);
   import cna_pkg::*;

   logic [XW-1:0] dsh;
   logic          is_div;
   logic          take_re;
   logic          take_im;
   logic [XW-1:0] rem_re_in;
   logic [XW-1:0] rem_im_in;
   logic [QW-1:0] q_re_in;
   logic [QW-1:0] q_im_in;

   always_comb begin
      dsh     = XW'(in_den) << BIT;
      is_div  = (in_flags.cmd == CMD_DIV);
      take_re = is_div && (in_rem_re >= dsh);
      take_im = is_div && (in_rem_im >= dsh);
      rem_re_in = take_re ? (in_rem_re - dsh) : in_rem_re;
      rem_im_in = take_im ? (in_rem_im - dsh) : in_rem_im;
      q_re_in = in_q_re;
      q_im_in = in_q_im;
      q_re_in[BIT] = take_re;
      q_im_in[BIT] = take_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_flags_ff  <= in_flags;
         out_den_ff    <= in_den;
         out_rem_re_ff <= rem_re_in;
         out_rem_im_ff <= rem_im_in;
         out_q_re_ff   <= q_re_in;
         out_q_im_ff   <= q_im_in;
      end
   end

endmodule

// ===== hw/rtl/cna_mul_stage.sv =====
module cna_mul_stage #(
   parameter int DW = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  cna_pkg::req_type     in_req,
   output logic                 out_valid_ff,
   output logic [1:0]           out_cmd_ff,
   output logic signed [DW:0]   out_as_re_ff,
   output logic signed [DW:0]   out_as_im_ff,
   output logic signed [2*DW-1:0] out_p_rr_ff,
   output logic signed [2*DW-1:0] out_p_ii_ff,
   output logic signed [2*DW-1:0] out_p_ri_ff,
   output logic signed [2*DW-1:0] out_p_ir_ff,
   output logic signed [2*DW-1:0] out_sq_r_ff,
   output logic signed [2*DW-1:0] out_sq_i_ff
);
   import cna_pkg::*;

   logic signed [DW-1:0] lr, li, rr, ri;
   logic signed [DW:0]   as_re_in, as_im_in;

   always_comb begin
      lr = in_req.left_real;
      li = in_req.left_imag;
      rr = in_req.right_real;
      ri = in_req.right_imag;
      if (in_req.cmd == CMD_SUB) begin
         as_re_in = (DW+1)'(lr) - (DW+1)'(rr);
         as_im_in = (DW+1)'(li) - (DW+1)'(ri);
      end else begin
         as_re_in = (DW+1)'(lr) + (DW+1)'(rr);
         as_im_in = (DW+1)'(li) + (DW+1)'(ri);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_cmd_ff   <= in_req.cmd;
         out_as_re_ff <= as_re_in;
         out_as_im_ff <= as_im_in;
         out_p_rr_ff  <= (2*DW)'(lr) * (2*DW)'(rr);
         out_p_ii_ff  <= (2*DW)'(li) * (2*DW)'(ri);
         out_p_ri_ff  <= (2*DW)'(lr) * (2*DW)'(ri);
         out_p_ir_ff  <= (2*DW)'(li) * (2*DW)'(rr);
         out_sq_r_ff  <= (2*DW)'(rr) * (2*DW)'(rr);
         out_sq_i_ff  <= (2*DW)'(ri) * (2*DW)'(ri);
      end
   end

endmodule

// ===== hw/rtl/cna_checker.sv =====
module cna_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input cna_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cna_pkg::rsp_type rsp_data
);
   import cna_pkg::*;

   // a held result keeps its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // input side only stalls when the output is blocked
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   // a stalled input item stays on the bus unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("input item changed while stalled");

   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_DZ |->
         rsp_data.result_real == '0 && rsp_data.result_imag == '0)
      else $error("divide by zero result not zero");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind complex_number_alu_unit cna_checker u_cna_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== test/tb_complex_number_alu_unit.sv =====
`timescale 1ns / 100ps

module tb_complex_number_alu_unit;
   import cna_pkg::*;

   localparam int LATENCY    = DATA_WIDTH + 5;
   localparam int IDLE_LIMIT = 4000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   complex_number_alu_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rsp_type expected_results[$];
   int      fail_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      quiet_cycles = 0;

   // Predict one result at full precision. Products of two 32-bit parts
   // need 64 bits; a shifted divide numerator needs about 82, so 200 is ample.
   function automatic rsp_type compute_complex(req_type r);
      logic signed [199:0] a, b, c, d, re, im, den;
      logic signed [199:0] hi, lo;
      rsp_type o;
      a = r.left_real;
      b = r.left_imag;
      c = r.right_real;
      d = r.right_imag;
      hi = (200'sd1 <<< (DATA_WIDTH - 1)) - 1;
      lo = -(200'sd1 <<< (DATA_WIDTH - 1));
      o = '0;
      case (r.cmd)
         CMD_ADD: begin
            re = a + c;
            im = b + d;
         end
         CMD_SUB: begin
            re = a - c;
            im = b - d;
         end
         CMD_MUL: begin
            re = a * c - b * d;
            im = a * d + b * c;
            // truncate toward zero: shift magnitude
            re = (re < 0) ? -((-re) >>> FRAC_BITS) : (re >>> FRAC_BITS);
            im = (im < 0) ? -((-im) >>> FRAC_BITS) : (im >>> FRAC_BITS);
         end
         default: begin
            den = c * c + d * d;
            if (den == 0) begin
               o.status = ST_DZ;
               return o;
            end
            // signed division truncates toward zero
            re = ((a * c + b * d) <<< FRAC_BITS) / den;
            im = ((b * c - a * d) <<< FRAC_BITS) / den;
         end
      endcase
      o.status = ST_OK;
      if (re > hi) begin
         re = hi;
         o.status = ST_SAT;
      end else if (re < lo) begin
         re = lo;
         o.status = ST_SAT;
      end
      if (im > hi) begin
         im = hi;
         o.status = ST_SAT;
      end else if (im < lo) begin
         im = lo;
         o.status = ST_SAT;
      end
      o.result_real = re[DATA_WIDTH-1:0];
      o.result_imag = im[DATA_WIDTH-1:0];
      return o;
   endfunction

   // Send one item: random gap first, then hold until accepted.
   // Valid stays high after acceptance until the next gap or the drain.
   task automatic send_item(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(compute_complex(r));
      @(negedge clock);
   endtask

   // Drive receiver stall at each falling edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Check each accepted result against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.result_real !== want.result_real) begin
               $error("result_real expected %h actual %h", want.result_real,
                      rsp_data.result_real);
               fail_count++;
            end
            if (rsp_data.result_imag !== want.result_imag) begin
               $error("result_imag expected %h actual %h", want.result_imag,
                      rsp_data.result_imag);
               fail_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status,
                      rsp_data.status);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: count cycles without any handshake.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_complex_number_alu_unit: FAIL");
            $finish;
         end
      end
   end

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
         4, 5: return $signed($urandom_range(32'h0010_0000)) -
                      $signed(32'h0008_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_item(logic [1:0] cmd, logic [31:0] lr,
                                         logic [31:0] li, logic [31:0] rr,
                                         logic [31:0] ri);
      req_type r;
      r.cmd        = cmd;
      r.left_real  = lr;
      r.left_imag  = li;
      r.right_real = rr;
      r.right_imag = ri;
      return r;
   endfunction

   // Extremes and special cases for every operation.
   task automatic test_directed();
      logic [1:0] ops[4];
      ops = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV};
      foreach (ops[i]) begin
         send_item(make_item(ops[i], 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h8000_0000));
         send_item(make_item(ops[i], 32'h0003_0000, 32'hFFFE_0000,
                             32'h0001_8000, 32'h0002_0000));
         send_item(make_item(ops[i], 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h0000_0001, 32'hFFFF_FFFF));
      end
      // zero divisor, including zero numerator
      send_item(make_item(CMD_DIV, 32'h0001_0000, 32'h0002_0000, '0, '0));
      send_item(make_item(CMD_DIV, '0, '0, '0, '0));
      // divide by smallest nonzero magnitude saturates
      send_item(make_item(CMD_DIV, 32'h7FFF_FFFF, '0, 32'h0000_0001, '0));
      // all-zero and all-ones patterns
      send_item(make_item(CMD_MUL, '0, '0, '0, '0));
      send_item(make_item(CMD_MUL, '1, '1, '1, '1));
      send_item(make_item(CMD_DIV, '1, '1, '1, '1));
   endtask

   // Random items with a mix of boundary and random operands.
   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         send_item(make_item(2'($urandom_range(3)), pick_operand(), pick_operand(),
                             pick_operand(), pick_operand()));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles 29%, receiver 69%
      send_idle_pct  = 29;
      recv_stall_pct = 69;
      test_directed();
      test_random(400);
      // swap the idle ratios
      send_idle_pct  = 69;
      recv_stall_pct = 29;
      test_random(400);
      // full throughput
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random(400);
      drain();

      if (fail_count == 0) begin
         $display("tb_complex_number_alu_unit: PASS");
      end else begin
         $display("tb_complex_number_alu_unit: FAIL");
      end
      $finish;
   end

endmodule
